FILE: rtl/agr_pkg.sv
// Package with shared constants and types of the gesture recognizer.
package agr_pkg;
  localparam int HistoryDepthDef = 128;

  localparam logic [2:0] ST_STILL = 3'd0;
  localparam logic [2:0] ST_RIGHT = 3'd1;
  localparam logic [2:0] ST_LEFT  = 3'd2;
  localparam logic [2:0] ST_UP    = 3'd3;
  localparam logic [2:0] ST_DOWN  = 3'd4;
  localparam logic [2:0] ST_FWD   = 3'd5;
  localparam logic [2:0] ST_BACK  = 3'd6;

  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_THR   = 2'd1;
  localparam logic [1:0] REG_HOLD  = 2'd2;
  localparam logic [1:0] REG_CAP   = 2'd3;

  // Configuration registers as one group.
  typedef struct packed {
    logic [7:0]  alpha;
    logic [14:0] thr;
    logic [3:0]  hold;
    logic [3:0]  cap;
  } cfg_t;

  // Gesture lengths and movement sequences, newest movement last.
  function automatic logic [2:0] gest_len(input logic [1:0] g);
    case (g)
      2'd0:    gest_len = 3'd2;
      2'd1:    gest_len = 3'd5;
      default: gest_len = 3'd6;
    endcase
  endfunction

  function automatic logic [2:0] gest_seq(input logic [1:0] g, input logic [2:0] k);
    logic [2:0] r;
    r = ST_STILL;
    case (g)
      2'd0: r = ST_DOWN;
      2'd1: begin
        case (k)
          3'd0: r = ST_RIGHT;
          3'd1: r = ST_DOWN;
          3'd2: r = ST_LEFT;
          3'd3: r = ST_DOWN;
          3'd4: r = ST_RIGHT;
          default: r = ST_STILL;
        endcase
      end
      default: begin
        case (k)
          3'd0: r = ST_RIGHT;
          3'd1: r = ST_DOWN;
          3'd2: r = ST_LEFT;
          3'd3: r = ST_RIGHT;
          3'd4: r = ST_DOWN;
          3'd5: r = ST_LEFT;
          default: r = ST_STILL;
        endcase
      end
    endcase
    gest_seq = r;
  endfunction
endpackage

FILE: rtl/agr_cfg.sv
// APB-style configuration register file.
module agr_cfg
  import agr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);
  cfg_t cfg_r;
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign cfg = cfg_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{alpha: 8'd26, thr: 15'd512, hold: 4'd3, cap: 4'd10};
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_ALPHA: cfg_r.alpha <= pwdata[7:0];
        REG_THR:   cfg_r.thr <= pwdata[14:0];
        REG_HOLD:  cfg_r.hold <= pwdata[3:0];
        REG_CAP:   cfg_r.cap <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_ALPHA: prdata = {24'd0, cfg_r.alpha};
        REG_THR:   prdata = {17'd0, cfg_r.thr};
        REG_HOLD:  prdata = {28'd0, cfg_r.hold};
        REG_CAP:   prdata = {28'd0, cfg_r.cap};
        default:   prdata = '0;
      endcase
    end
  end
endmodule

FILE: rtl/accel_gesture_recognizer.sv
// Top level of the accelerometer gesture recognizer.
// A sample item updates the three low-pass filters one axis after another, each
// with a multiply step and an accumulate step on a shared 8x25 multiplier. A capture
// tick classifies, updates the run ring and matches gestures one movement per cycle
// (at most 13 reads). After a still run of at least the hold length it first walks
// back through the run ring one entry per cycle (at most HISTORY_DEPTH reads of its
// memory port) and commits the run found as a movement; a failed walk or a run
// committed before ends the tick. After reset a clearing pass writes every entry
// of both rings before the first item is accepted. The result is held in an
// output register until taken. The next item is accepted only once the last one
// has entered it, and its result waits until the register is free.
module accel_gesture_recognizer
  import agr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HistoryDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_filt_x,
  output logic signed [15:0] out_filt_y,
  output logic signed [15:0] out_filt_z,
  output logic [2:0]         out_micro_state,
  output logic               out_movement_valid,
  output logic [2:0]         out_last_movement,
  output logic [15:0]        out_movement_total,
  output logic               out_gesture_valid,
  output logic [1:0]         out_last_gesture,
  output logic [15:0]        out_gesture_total,
  output logic               out_search_failed,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(HISTORY_DEPTH - 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FILT  = 4'd2;
  localparam logic [3:0] S_FACC  = 4'd3;
  localparam logic [3:0] S_RRD   = 4'd4;
  localparam logic [3:0] S_RUPD  = 4'd5;
  localparam logic [3:0] S_WRD   = 4'd6;
  localparam logic [3:0] S_WCHK  = 4'd7;
  localparam logic [3:0] S_CRD   = 4'd8;
  localparam logic [3:0] S_CCHK  = 4'd9;
  localparam logic [3:0] S_GRD   = 4'd10;
  localparam logic [3:0] S_GCHK  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  cfg_t cfg;
  agr_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  // Ring memories: run entries {state, length, done} and moves {state, done}.
  logic [7:0] run_mem [HISTORY_DEPTH];
  logic [3:0] mov_mem [HISTORY_DEPTH];
  logic [7:0] run_rd_r;
  logic [3:0] mov_rd_r;
  logic [AW-1:0] run_ra, mov_ra, run_wa, mov_wa;
  logic [7:0] run_wd;
  logic [3:0] mov_wd;
  logic run_we, mov_we;

  always_ff @(posedge clk) begin
    if (run_we) run_mem[run_wa] <= run_wd;
    run_rd_r <= run_mem[run_ra];
  end
  always_ff @(posedge clk) begin
    if (mov_we) mov_mem[mov_wa] <= mov_wd;
    mov_rd_r <= mov_mem[mov_ra];
  end

  logic [3:0] st_r, st_nxt;
  logic signed [23:0] fx_r, fy_r, fz_r;
  logic [1:0] ax_r, ax_nxt;
  logic signed [15:0] ix_r, iy_r, iz_r;
  logic signed [33:0] prod_r;
  logic [AW-1:0] rwp_r, mwp_r, cur_r, cand_r;
  logic [CW-1:0] cnt_r;
  logic [2:0] ns_r;     // newest run state
  logic [7:0] newrun_r; // newest run entry as written this tick
  logic [15:0] mcnt_r, gcnt_r;
  logic [1:0] glast_r;
  logic [2:0] lastmv_r;
  logic mv_r, gv_r, fail_r, first_r;
  logic [1:0] g_r;
  logic [2:0] k_r;
  logic [AW-1:0] gp_r;
  logic ov_r;

  // Input and filter state of the current axis.
  logic signed [15:0] xin;
  logic signed [23:0] fcur;
  always_comb begin
    case (ax_r)
      2'd0:    begin xin = ix_r; fcur = fx_r; end
      2'd1:    begin xin = iy_r; fcur = fy_r; end
      default: begin xin = iz_r; fcur = fz_r; end
    endcase
  end
  logic signed [24:0] diff;
  assign diff = {xin[15], xin, 8'd0} - {fcur[23], fcur};
  logic signed [23:0] fnew;
  assign fnew = fcur + 24'(prod_r >>> 8);

  // Classification of the filtered vector.
  logic signed [23:0] tpos, tneg;
  logic [2:0] cls;
  assign tpos = {1'b0, cfg.thr, 8'd0};
  assign tneg = -tpos;
  always_comb begin
    if (fx_r < tneg)      cls = ST_LEFT;
    else if (fx_r > tpos) cls = ST_RIGHT;
    else if (fy_r < tneg) cls = ST_BACK;
    else if (fy_r > tpos) cls = ST_FWD;
    else if (fz_r < tneg) cls = ST_DOWN;
    else if (fz_r > tpos) cls = ST_UP;
    else                  cls = ST_STILL;
  end

  logic [3:0] capv;
  assign capv = (cfg.cap == 4'd0) ? 4'd1 : cfg.cap;
  logic [3:0] len_inc;
  assign len_inc = (run_rd_r[4:1] >= capv) ? capv : run_rd_r[4:1] + 4'd1;

  function automatic logic [AW-1:0] bk(input logic [AW-1:0] i);
    bk = (i == '0) ? LastIdx : i - AW'(1);
  endfunction
  function automatic logic [AW-1:0] fw(input logic [AW-1:0] i);
    fw = (i == LastIdx) ? '0 : i + AW'(1);
  endfunction

  logic qual;
  assign qual = run_rd_r[7:5] == ST_STILL && run_rd_r[4:1] >= cfg.hold;
  logic gmatch;
  assign gmatch = !mov_rd_r[0] && mov_rd_r[3:1] == gest_seq(g_r, k_r);

  // A finished item moves into the output register once it is free.
  logic done_go;
  assign done_go = st_r == S_DONE && (!ov_r || out_ready);

  assign in_ready = st_r == S_IDLE;

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; fx_r <= '0; fy_r <= '0; fz_r <= '0;
      rwp_r <= AW'(1); mwp_r <= AW'(1); mcnt_r <= 16'd1; gcnt_r <= '0;
      glast_r <= '0; cnt_r <= '0; ov_r <= 1'b0; ns_r <= ST_STILL;
      lastmv_r <= ST_STILL; ax_r <= '0;
    end else begin
      st_r <= st_nxt;
      ax_r <= ax_nxt;
      if (done_go) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (st_r)
        S_CLR: cnt_r <= cnt_r + CW'(1);
        S_IDLE: begin
          if (in_valid && in_ready) begin
            ix_r <= in_accel_x; iy_r <= in_accel_y; iz_r <= in_accel_z;
            mv_r <= 1'b0; gv_r <= 1'b0; fail_r <= 1'b0;
          end
        end
        S_FILT: prod_r <= $signed({1'b0, cfg.alpha}) * diff;
        S_FACC: begin
          case (ax_r)
            2'd0:    fx_r <= fnew;
            2'd1:    fy_r <= fnew;
            default: fz_r <= fnew;
          endcase
        end
        S_RUPD: begin
          if (cls != run_rd_r[7:5]) rwp_r <= fw(rwp_r);
          ns_r <= cls;
          newrun_r <= run_wd;
          cur_r <= (cls != run_rd_r[7:5]) ? bk(rwp_r) : bk(bk(rwp_r));
          cand_r <= (cls != run_rd_r[7:5]) ? bk(rwp_r) : bk(bk(rwp_r));
          cnt_r <= '0;
          first_r <= 1'b1;
        end
        S_WCHK: begin
          if (!qual) begin
            cand_r <= cur_r; cur_r <= bk(cur_r); cnt_r <= cnt_r + CW'(1);
            first_r <= 1'b0;
            if (cnt_r == CW'(HISTORY_DEPTH - 1)) fail_r <= 1'b1;
          end else if (first_r) begin
            cand_r <= cur_r;
          end
        end
        S_CCHK: begin
          if (!run_rd_r[0] && run_rd_r[7:5] != ST_STILL) begin
            mwp_r <= fw(mwp_r); mcnt_r <= mcnt_r + 16'd1; mv_r <= 1'b1;
            lastmv_r <= run_rd_r[7:5];
          end
        end
        S_GRD: ;
        S_GCHK: begin
          if (k_r == 3'd0 && gp_r == bk(mwp_r) && mov_rd_r[0]) begin
            g_r <= 2'd0;
          end else if (gmatch && k_r == 3'd0) begin
            gv_r <= 1'b1; glast_r <= g_r + 2'd1; gcnt_r <= gcnt_r + 16'd1;
          end else if (gmatch) begin
            k_r <= k_r - 3'd1; gp_r <= bk(gp_r);
          end else begin
            g_r <= g_r + 2'd1; k_r <= gest_len(g_r + 2'd1) - 3'd1; gp_r <= bk(mwp_r);
          end
        end
        default: ;
      endcase
      // Gesture search start.
      if (st_nxt == S_GRD && st_r != S_GCHK) begin
        g_r <= 2'd0; k_r <= gest_len(2'd0) - 3'd1;
        gp_r <= (st_r == S_CCHK && !run_rd_r[0] && run_rd_r[7:5] != ST_STILL)
                ? mwp_r : bk(mwp_r);
      end
    end
  end

  // Next state, memory ports.
  always_comb begin
    st_nxt = st_r; ax_nxt = ax_r;
    run_ra = bk(rwp_r); mov_ra = gp_r;
    run_we = 1'b0; run_wa = rwp_r; run_wd = '0;
    mov_we = 1'b0; mov_wa = mwp_r; mov_wd = '0;
    case (st_r)
      S_CLR: begin
        run_we = 1'b1; mov_we = 1'b1;
        run_wa = cnt_r[AW-1:0]; mov_wa = cnt_r[AW-1:0];
        run_wd = {ST_STILL, (cnt_r == '0) ? 4'd10 : 4'd1, 1'b0};
        mov_wd = {ST_STILL, 1'b0};
        if (cnt_r == CW'(HISTORY_DEPTH - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid && in_ready) begin
        st_nxt = in_action ? S_RRD : S_FILT; ax_nxt = '0;
      end
      S_FILT: st_nxt = S_FACC;
      S_FACC: begin
        if (ax_r == 2'd2) st_nxt = S_DONE;
        else begin st_nxt = S_FILT; ax_nxt = ax_r + 2'd1; end
      end
      S_RRD: st_nxt = S_RUPD;
      S_RUPD: begin
        run_we = 1'b1;
        if (cls != run_rd_r[7:5]) begin
          run_wa = rwp_r; run_wd = {cls, 4'd1, 1'b0};
          if (cls == ST_STILL && cfg.hold <= 4'd1) st_nxt = S_WRD;
          else st_nxt = S_GRD;
        end else begin
          run_wa = bk(rwp_r); run_wd = {cls, len_inc, 1'b0};
          if (cls == ST_STILL && len_inc >= cfg.hold) st_nxt = S_WRD;
          else st_nxt = S_GRD;
        end
      end
      S_WRD: begin run_ra = cur_r; st_nxt = S_WCHK; end
      S_WCHK: begin
        if (qual) st_nxt = S_CRD;
        else if (cnt_r == CW'(HISTORY_DEPTH - 1)) st_nxt = S_DONE;
        else begin run_ra = bk(cur_r); st_nxt = S_WCHK; end
        if (!qual) run_ra = bk(cur_r);
      end
      S_CRD: begin run_ra = cand_r; st_nxt = S_CCHK; end
      S_CCHK: begin
        if (run_rd_r[0]) st_nxt = S_DONE;
        else begin
          // The run after the found one is the candidate or else the newest run.
          run_we = 1'b1; run_wa = fw(cur_r);
          run_wd = (fw(cur_r) == cand_r) ? {run_rd_r[7:1], 1'b1}
                                         : {newrun_r[7:1], 1'b1};
          mov_we = run_rd_r[7:5] != ST_STILL;
          mov_wd = {run_rd_r[7:5], 1'b0};
          st_nxt = S_GRD;
        end
      end
      S_GRD: st_nxt = S_GCHK;
      S_GCHK: begin
        if (k_r == 3'd0 && gp_r == bk(mwp_r) && mov_rd_r[0]) st_nxt = S_DONE;
        else if (gmatch && k_r == 3'd0) begin
          mov_we = 1'b1; mov_wa = bk(mwp_r); mov_wd = {lastmv_r, 1'b1};
          st_nxt = S_DONE;
        end else if (gmatch) begin mov_ra = bk(gp_r); st_nxt = S_GCHK; end
        else if (g_r == 2'd2) st_nxt = S_DONE;
        else begin mov_ra = bk(mwp_r); st_nxt = S_GCHK; end
      end
      S_DONE: if (done_go) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (done_go) begin
      out_filt_x <= 16'(fx_r >>> 8);
      out_filt_y <= 16'(fy_r >>> 8);
      out_filt_z <= 16'(fz_r >>> 8);
      out_micro_state <= ns_r;
      out_movement_valid <= mv_r;
      out_last_movement <= lastmv_r;
      out_movement_total <= mcnt_r;
      out_gesture_valid <= gv_r;
      out_last_gesture <= glast_r;
      out_gesture_total <= gcnt_r;
      out_search_failed <= fail_r;
    end
  end
  assign out_valid = ov_r;
endmodule

FILE: rtl/agr_checker.sv
// Port-level checker of the gesture recognizer, bound to the top level.
module agr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_movement_valid,
  input logic       out_search_failed,
  input logic       out_gesture_valid,
  input logic [15:0] out_movement_total
);
  // The block is busy right after it takes an item.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("item accepted while busy");
  // A failed walk never commits a movement or a gesture.
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_search_failed |-> !out_movement_valid && !out_gesture_valid)
    else $error("failed walk with commit");
  // A held result stays valid and keeps its movement total.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_movement_total))
    else $error("result changed while stalled");
endmodule

bind accel_gesture_recognizer agr_checker u_agr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_movement_valid(out_movement_valid), .out_search_failed(out_search_failed),
  .out_gesture_valid(out_gesture_valid), .out_movement_total(out_movement_total)
);
